// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked on every clock edge outside reset
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`else

`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg)

`define ASSERT_CLK(label, clk, prop, msg)

`endif

`endif

// File: design/grs_pkg.sv
// ----------------------------------------------------------------------------
// grs_pkg
// shared constants and fixed-point helpers for the givens rotation sequence
// ----------------------------------------------------------------------------
package grs_pkg;

  localparam int unsigned LANES  = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned QBITS  = 30;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam data_t ONE_Q      = data_t'(1) <<< QBITS;
  localparam data_t MINUS_ONE_Q = -(data_t'(1) <<< QBITS);
  localparam prod_t HALF_Q     = prod_t'(1) <<< (QBITS - 1);
  localparam prod_t SAT_MAX    = prod_t'({1'b0, {(DATA_W-1){1'b1}}});
  localparam prod_t SAT_MIN    = -prod_t'({1'b1, {(DATA_W-1){1'b0}}});

  // limit a coefficient to plus or minus one
  function automatic data_t clamp_coef(data_t c);
    data_t r;
    r = c;
    if (c > ONE_Q) begin
      r = ONE_Q;
    end else if (c < MINUS_ONE_Q) begin
      r = MINUS_ONE_Q;
    end
    return r;
  endfunction

  // round half up, drop the fraction bits, saturate to the data width
  function automatic data_t round_sat(prod_t s);
    prod_t r;
    prod_t q;
    data_t res;
    r = s + HALF_Q;
    q = r >>> QBITS;
    if (q > SAT_MAX) begin
      res = data_t'(SAT_MAX);
    end else if (q < SAT_MIN) begin
      res = data_t'(SAT_MIN);
    end else begin
      res = data_t'(q);
    end
    return res;
  endfunction

endpackage

// File: design/grs_if.sv
// ----------------------------------------------------------------------------
// grs channel interfaces
// column request channel and result channel of the rotation sequence
// ----------------------------------------------------------------------------
interface grs_in_if;
  logic               valid;
  logic               ready;
  logic               first_column;
  logic               last_column;
  logic signed [31:0] gamma;
  logic signed [31:0] sigma;
  logic signed [31:0] lane_in_0;
  logic signed [31:0] lane_in_1;
  logic signed [31:0] lane_in_2;
  logic signed [31:0] lane_in_3;

  modport source (
    output valid, first_column, last_column, gamma, sigma,
           lane_in_0, lane_in_1, lane_in_2, lane_in_3,
    input  ready
  );

  modport sink (
    input  valid, first_column, last_column, gamma, sigma,
           lane_in_0, lane_in_1, lane_in_2, lane_in_3,
    output ready
  );
endinterface

interface grs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] lane_out_0;
  logic signed [31:0] lane_out_1;
  logic signed [31:0] lane_out_2;
  logic signed [31:0] lane_out_3;
  logic               run_end;

  modport source (
    output valid, lane_out_0, lane_out_1, lane_out_2, lane_out_3, run_end,
    input  ready
  );

  modport sink (
    input  valid, lane_out_0, lane_out_1, lane_out_2, lane_out_3, run_end,
    output ready
  );
endinterface

// File: design/givens_rotation_sequence.sv
// ----------------------------------------------------------------------------
// givens_rotation_sequence
// applies a chain of plane rotations to adjacent columns of a four-row block
// ----------------------------------------------------------------------------
// Columns enter one per cycle while the result side is not stalled and no
// final carry is pending. A request is registered, rotated against the
// carried column and the result leaves from an output register. A column
// that closes a run of two or more produces two results, and the final
// carried column leaves behind the rotated one; no new column is processed
// while the final carry is pending. The carry update (a 32x32 multiply, a
// 64-bit add, rounding and saturation) is the loop that sets the clock
// period. A stalled result side holds at most one request in the input
// register before backpressure reaches the column source.
module givens_rotation_sequence (
  input  logic clk_i,
  input  logic rst_ni,
  grs_in_if.sink    in_i,
  grs_out_if.source out_o
);
  import grs_pkg::*;

  `include "assert_macros.svh"

  // input register
  logic  s1_valid_q;
  logic  s1_first_q;
  logic  s1_last_q;
  data_t s1_gamma_q;
  data_t s1_sigma_q;
  data_t s1_lane_q [LANES];

  // carried column and output register
  data_t carry_q   [LANES];
  data_t carry_d   [LANES];
  logic  out_valid_q, out_valid_d;
  logic  out_run_end_q, out_run_end_d;
  data_t out_lane_q [LANES];
  data_t out_lane_d [LANES];
  logic  tail_q, tail_d;

  logic  in_fire;
  logic  out_free;
  logic  s1_go;
  logic  tail_go;

  data_t emit_lane [LANES];
  data_t keep_lane [LANES];
  data_t in_lane   [LANES];

  assign in_lane[0] = in_i.lane_in_0;
  assign in_lane[1] = in_i.lane_in_1;
  assign in_lane[2] = in_i.lane_in_2;
  assign in_lane[3] = in_i.lane_in_3;

  assign out_free = !out_valid_q || out_o.ready;
  assign tail_go  = tail_q && out_free;
  assign s1_go    = s1_valid_q && !tail_q && out_free;
  assign in_i.ready = !s1_valid_q || s1_go;
  assign in_fire  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire || (s1_valid_q && !s1_go);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_first_q <= in_i.first_column;
      s1_last_q  <= in_i.last_column;
      s1_gamma_q <= in_i.gamma;
      s1_sigma_q <= in_i.sigma;
      for (int l = 0; l < LANES; l++) begin
        s1_lane_q[l] <= in_lane[l];
      end
    end
  end

  // per-lane rotation, lanes are independent
  always_comb begin
    data_t g;
    data_t s;
    g = clamp_coef(s1_gamma_q);
    s = clamp_coef(s1_sigma_q);
    for (int l = 0; l < LANES; l++) begin
      emit_lane[l] = round_sat(prod_t'(g) * prod_t'(carry_q[l])
                             + prod_t'(s) * prod_t'(s1_lane_q[l]));
      keep_lane[l] = round_sat(prod_t'(g) * prod_t'(s1_lane_q[l])
                             - prod_t'(s) * prod_t'(carry_q[l]));
    end
  end

  always_comb begin
    carry_d       = carry_q;
    out_valid_d   = out_valid_q;
    out_run_end_d = out_run_end_q;
    out_lane_d    = out_lane_q;
    tail_d        = tail_q;
    if (out_free) begin
      out_valid_d = 1'b0;
    end
    if (tail_go) begin
      // final carry of a run goes out behind its rotated column
      out_valid_d   = 1'b1;
      out_run_end_d = 1'b1;
      out_lane_d    = carry_q;
      tail_d        = 1'b0;
    end else if (s1_go) begin
      if (s1_first_q) begin
        carry_d = s1_lane_q;
        if (s1_last_q) begin
          out_valid_d   = 1'b1;
          out_run_end_d = 1'b1;
          out_lane_d    = s1_lane_q;
        end
      end else begin
        carry_d       = keep_lane;
        out_valid_d   = 1'b1;
        out_run_end_d = 1'b0;
        out_lane_d    = emit_lane;
        tail_d        = s1_last_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      tail_q      <= 1'b0;
      for (int l = 0; l < LANES; l++) begin
        carry_q[l] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      tail_q      <= tail_d;
      carry_q     <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_run_end_q <= out_run_end_d;
    out_lane_q    <= out_lane_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.run_end    = out_run_end_q;
  assign out_o.lane_out_0 = out_lane_q[0];
  assign out_o.lane_out_1 = out_lane_q[1];
  assign out_o.lane_out_2 = out_lane_q[2];
  assign out_o.lane_out_3 = out_lane_q[3];

  `ASSERT_CLK_RST(a_tail_blocks_column, clk_i, rst_ni,
    tail_q |-> !s1_go, "column processed while final carry still pending")
  `ASSERT_CLK_RST(a_tail_has_output, clk_i, rst_ni,
    tail_q |-> out_valid_q, "final carry pending without rotated column out")
  `ASSERT_CLK_RST(a_tail_marks_end, clk_i, rst_ni,
    tail_go |=> (out_valid_q && out_run_end_q), "final carry left without run end")
  `ASSERT_CLK_RST(a_full_stalls_input, clk_i, rst_ni,
    (s1_valid_q && tail_q) |-> !in_i.ready, "request taken over a held column")

endmodule
